### rtl/core/hbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the Huffman tree bit decoder.
// Depends on nothing; every other file of the block imports it.
package hbd_pkg;

	localparam int unsigned IDX_W     = 9;
	localparam int unsigned SYM_W     = 8;
	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned BIT_CNT_W = $clog2(BYTE_BITS);

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [IDX_W-1:0] node_index;
		logic             node_leaf;
		logic [SYM_W-1:0] node_symbol;
		logic [IDX_W-1:0] left_child;
		logic [IDX_W-1:0] right_child;
		logic [SYM_W-1:0] data_byte;
	} hbd_in_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last_of_byte;
	} hbd_out_t;

	// One node table entry.
	typedef struct packed {
		logic             leaf;
		logic [SYM_W-1:0] node_symbol;
		logic [IDX_W-1:0] left_child;
		logic [IDX_W-1:0] right_child;
	} node_t;

	// Node table port request from the walker.
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_index;
		node_t            wr_node;
		logic             rd_en;
		logic [IDX_W-1:0] rd_index;
	} mem_req_t;

	// Symbol hand-off from the walker to the output buffer.
	typedef struct packed {
		logic             push;
		logic             flush;
		logic [SYM_W-1:0] symbol;
	} push_t;

	// True when an index addresses a real entry of a table of count nodes.
	function automatic logic in_table(input logic [IDX_W-1:0] idx, input int unsigned count);
		in_table = 32'(idx) < count;
	endfunction

endpackage

### rtl/core/hbd_node_mem.sv
`timescale 1ns / 1ps
// Node table of the decoder: one write port and one registered read port.
// Depends on hbd_pkg.
module hbd_node_mem #(
	parameter int unsigned NODE_COUNT = 512
) (
	input  logic             clk,
	input  hbd_pkg::mem_req_t req,
	output hbd_pkg::node_t   rd_node
);
	import hbd_pkg::*;

	localparam int unsigned AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int unsigned EXT_W = IDX_W + AW;

	node_t            node_mem [NODE_COUNT];
	node_t            rd_q;
	logic             oob_q;
	logic [EXT_W-1:0] wr_ext;
	logic [EXT_W-1:0] rd_ext;
	logic             rd_in;

	assign wr_ext = EXT_W'(req.wr_index);
	assign rd_ext = EXT_W'(req.rd_index);
	assign rd_in  = in_table(req.rd_index, NODE_COUNT);

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			node_mem[wr_ext[AW-1:0]] <= req.wr_node;
		end
		if (req.rd_en) begin
			oob_q <= !rd_in;
			if (rd_in) begin
				rd_q <= node_mem[rd_ext[AW-1:0]];
			end
		end
	end

	// An index past the table reads as an all-zero interior node.
	assign rd_node = oob_q ? '0 : rd_q;

endmodule

### rtl/core/hbd_sym_buf.sv
`timescale 1ns / 1ps
// Output side of the decoder: holds the newest symbol until it is known whether
// it closes its byte, then moves it into the result register. Depends on hbd_pkg.
module hbd_sym_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  hbd_pkg::push_t    push,
	output logic              push_ready,
	output logic              result_valid,
	input  logic              result_ready,
	output hbd_pkg::hbd_out_t result
);
	import hbd_pkg::*;

	logic             pend_valid_q;
	logic [SYM_W-1:0] pend_sym_q;
	logic             out_valid_q;
	hbd_out_t         out_q;
	logic             slot_free;
	logic             load_out;

	assign slot_free  = !out_valid_q || result_ready;
	assign push_ready = !pend_valid_q || slot_free;
	assign load_out   = pend_valid_q && slot_free && (push.push || push.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push.push && push_ready) begin
				pend_valid_q <= 1'b1;
			end else if (push.flush && push_ready) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.push && push_ready) begin
			pend_sym_q <= push.symbol;
		end
		if (load_out) begin
			out_q.symbol       <= pend_sym_q;
			out_q.last_of_byte <= push.flush;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### rtl/core/hbd_walk.sv
`timescale 1ns / 1ps
// Tree walker of the decoder: handshakes, root register, bit shift register and the
// walk over the node table, one bit per cycle unless the output stalls. Depends on hbd_pkg.
module hbd_walk #(
	parameter int unsigned NODE_COUNT = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  hbd_pkg::hbd_in_t      item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [hbd_pkg::IDX_W-1:0] cfg_data,
	output hbd_pkg::mem_req_t     mem_req,
	input  hbd_pkg::node_t        rd_node,
	output hbd_pkg::push_t        push,
	input  logic                  push_ready
);
	import hbd_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROOT  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]           state_q;
	logic [IDX_W-1:0]     root_q;
	logic [IDX_W-1:0]     root_left_q;
	logic [IDX_W-1:0]     root_right_q;
	logic [IDX_W-1:0]     cur_idx_q;
	logic [IDX_W-1:0]     cur_left_q;
	logic [IDX_W-1:0]     cur_right_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [BYTE_BITS-2:0] shift_q;
	logic [BIT_CNT_W-1:0] bit_q;

	logic             cfg_fire;
	logic             item_fire;
	logic             load_fire;
	logic             dec_fire;
	logic             load_in;
	logic             walk_adv;
	logic             last_bit;
	logic [IDX_W-1:0] nx_idx;
	logic [IDX_W-1:0] nx_left;
	logic [IDX_W-1:0] nx_right;
	logic [IDX_W-1:0] nx_addr;

	assign cfg_ready  = (state_q == ST_IDLE);
	assign item_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign item_fire  = item_valid && item_ready;
	assign load_fire  = item_fire && (item.operation == OP_LOAD);
	assign dec_fire   = item_fire && (item.operation == OP_DECODE);
	assign load_in    = load_fire && in_table(item.node_index, NODE_COUNT);

	// After a leaf the walk restarts from the root's children.
	assign nx_idx   = rd_node.leaf ? root_q       : rd_idx_q;
	assign nx_left  = rd_node.leaf ? root_left_q  : rd_node.left_child;
	assign nx_right = rd_node.leaf ? root_right_q : rd_node.right_child;
	assign nx_addr  = shift_q[0] ? nx_right : nx_left;

	assign last_bit = (bit_q == BIT_CNT_W'(BYTE_BITS - 1));
	assign walk_adv = (state_q == ST_WALK) && (!rd_node.leaf || push_ready);

	assign push.push   = (state_q == ST_WALK) && rd_node.leaf;
	assign push.flush  = (state_q == ST_FLUSH);
	assign push.symbol = rd_node.node_symbol;

	always_comb begin
		mem_req.wr_en                   = load_in;
		mem_req.wr_index                = item.node_index;
		mem_req.wr_node.leaf            = item.node_leaf;
		mem_req.wr_node.node_symbol     = item.node_symbol;
		mem_req.wr_node.left_child      = item.left_child;
		mem_req.wr_node.right_child     = item.right_child;
		mem_req.rd_en                   = cfg_fire || dec_fire || (walk_adv && !last_bit);
		if (cfg_fire) begin
			mem_req.rd_index = cfg_data;
		end else if (dec_fire) begin
			mem_req.rd_index = item.data_byte[0] ? cur_right_q : cur_left_q;
		end else begin
			mem_req.rd_index = nx_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			root_q       <= '0;
			root_left_q  <= '0;
			root_right_q <= '0;
			cur_idx_q    <= '0;
			cur_left_q   <= '0;
			cur_right_q  <= '0;
			bit_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_fire) begin
						root_q  <= cfg_data;
						state_q <= ST_ROOT;
					end else if (dec_fire) begin
						bit_q   <= '0;
						state_q <= ST_WALK;
					end else if (load_in) begin
						// Keep the cached children coherent with the table.
						if (item.node_index == cur_idx_q) begin
							cur_left_q  <= item.left_child;
							cur_right_q <= item.right_child;
						end
						if (item.node_index == root_q) begin
							root_left_q  <= item.left_child;
							root_right_q <= item.right_child;
						end
					end
				end
				ST_ROOT: begin
					root_left_q  <= rd_node.left_child;
					root_right_q <= rd_node.right_child;
					cur_idx_q    <= root_q;
					cur_left_q   <= rd_node.left_child;
					cur_right_q  <= rd_node.right_child;
					state_q      <= ST_IDLE;
				end
				ST_WALK: begin
					if (walk_adv) begin
						cur_idx_q   <= nx_idx;
						cur_left_q  <= nx_left;
						cur_right_q <= nx_right;
						bit_q       <= bit_q + 1'b1;
						if (last_bit) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.rd_en) begin
			rd_idx_q <= mem_req.rd_index;
		end
		if (dec_fire) begin
			shift_q <= item.data_byte[BYTE_BITS-1:1];
		end else if (walk_adv) begin
			shift_q <= shift_q >> 1;
		end
	end

endmodule

### rtl/core/huffman_tree_bit_decoder.sv
`timescale 1ns / 1ps
// Top level of the Huffman tree bit decoder: walker, node table and output buffer.
// Depends on hbd_pkg, hbd_node_mem, hbd_sym_buf and hbd_walk.
//
// Usage. The item channel (item_valid, item_ready, item) carries two kinds of
// transaction. A load transaction writes one node of the code tree into the
// node table. A decode transaction carries one compressed byte whose bits are
// walked least significant first, one bit per cycle unless the output stalls,
// each bit costing one read of the node table that depends on the read before
// it. Every leaf reached yields one transaction on the result channel
// (result_valid, result_ready, result); the last symbol completed within a byte
// has last_of_byte set. A code may run across byte boundaries.
// With a receiver that keeps up, a decode transaction occupies the block for its
// bit steps, a step to hand over the held symbol and a return to idle; after the
// final bit step, its last symbol passes the held-symbol and result registers.
// The cfg channel writes the root index; the block then pauses while the root
// node is read back so that its children are cached. The walk then restarts at
// the new root. When the receiver stalls, the block holds at most two symbols:
// one in the result register and one waiting for its last_of_byte flag. The next
// leaf or the end of the byte then holds the whole walk until the result
// register drains, and item_ready stays low meanwhile.
// Reset clears the root index to zero and the walk position to the root; the
// node table itself is not cleared and must be loaded before decoding.
module huffman_tree_bit_decoder #(
	parameter int unsigned NODE_COUNT = 512
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  hbd_pkg::hbd_in_t          item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output hbd_pkg::hbd_out_t         result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [hbd_pkg::IDX_W-1:0] cfg_data
);
	import hbd_pkg::*;

	mem_req_t mem_req;
	node_t    rd_node;
	push_t    push;
	logic     push_ready;

	// Control: handshakes, root cache and the bit-serial walk.
	hbd_walk #(
		.NODE_COUNT (NODE_COUNT)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mem_req    (mem_req),
		.rd_node    (rd_node),
		.push       (push),
		.push_ready (push_ready)
	);

	// The node table, read once per walked bit.
	hbd_node_mem #(
		.NODE_COUNT (NODE_COUNT)
	) u_node_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_node (rd_node)
	);

	// One held symbol plus the result register; the held symbol learns its
	// last_of_byte flag when the next symbol or the end of the byte arrives.
	hbd_sym_buf u_sym_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_ready   (push_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef ASSERT_OFF
	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && (item.operation == OP_DECODE)) |=> !item_ready)
		else $error("decoder took a new transaction right after a decode transaction");

	a_root_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (!item_ready && !cfg_ready))
		else $error("decoder did not pause for the root node fetch");

	a_push_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.push && push.flush))
		else $error("symbol push and end-of-byte flush raised together");

	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> !mem_req.rd_en)
		else $error("node table written while a walk read is issued");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Huffman tree bit decoder: code trees are loaded node by node,
// compressed bytes are walked, and every symbol is checked against a tree walk kept here.
// Depends on hbd_pkg and huffman_tree_bit_decoder.
module testbench;
	import hbd_pkg::*;

	localparam int NODES        = 512;
	// Cycles to wait after the last expected symbol before touching the root register. A decode
	// transaction that yields no symbol still keeps the walker busy through its walk and flush.
	localparam int SETTLE_CYCLES = 24;
	// Length of the one long receiver hold-off that fills the block up.
	localparam int HOLD_CYCLES  = 400;
	// The longest correct quiet stretch is the receiver hold-off, so this is well clear of it.
	localparam int QUIET_LIMIT  = 4000;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_ready;
	hbd_in_t             item         = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	hbd_out_t            result;
	logic                cfg_valid    = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_data     = '0;

	huffman_tree_bit_decoder #(
		.NODE_COUNT(NODES)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Our own copy of the code tree and of the walk position. These are only touched by the
	// stimulus process, at the clock edge where the transaction that changes them is accepted.
	node_t            tree_mem [NODES];
	bit               tree_written [NODES];
	logic [IDX_W-1:0] written_list[$];
	logic [IDX_W-1:0] tree_root = '0;
	logic [IDX_W-1:0] walk_pos  = '0;

	// Symbols the block still owes us, oldest first.
	hbd_out_t pending_syms[$];

	int errors       = 0;
	int sent_items   = 0;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_trigger = 0;

	// A load transaction stores one node. Indexes beyond the table are dropped, which cannot
	// happen with a 512-entry table and 9-bit indexes, but the guard keeps the walk honest.
	function automatic void store_node(input hbd_in_t it);
		if (int'(it.node_index) < NODES) begin
			if (!tree_written[it.node_index]) begin
				tree_written[it.node_index] = 1'b1;
				written_list.insert(written_list.size(), it.node_index);
			end
			tree_mem[it.node_index] = '{it.node_leaf, it.node_symbol, it.left_child,
				it.right_child};
		end
	endfunction

	// Walk the eight bits of one compressed byte, least significant first. The node we stand on
	// is always left through its children, even when it is a leaf (a leaf root that points at
	// itself emits on every bit). Only the node we arrive at is tested for being a leaf.
	function automatic void walk_byte(input logic [7:0] bits);
		hbd_out_t         found[8];
		node_t            here;
		node_t            there;
		logic [IDX_W-1:0] nxt;
		int               count;
		count = 0;
		for (int b = 0; b < 8; b++) begin
			here  = tree_mem[walk_pos];
			nxt   = bits[b] ? here.right_child : here.left_child;
			there = (int'(nxt) < NODES) ? tree_mem[nxt] : '0;
			if (there.leaf) begin
				found[count] = '{there.node_symbol, 1'b0};
				count++;
				walk_pos = tree_root;
			end else begin
				walk_pos = nxt;
			end
		end
		// Only the final symbol completed inside this byte carries the last-of-byte flag.
		for (int k = 0; k < count; k++) begin
			found[k].last_of_byte = (k == count - 1);
			pending_syms.insert(pending_syms.size(), found[k]);
		end
	endfunction

	// Every child pointer we generate points at a node that is already written, so no walk
	// can ever read an entry that was never loaded.
	function automatic logic [IDX_W-1:0] any_written();
		return written_list[$urandom_range(written_list.size() - 1)];
	endfunction

	// The data byte of a load is ignored by the block, so it is always random noise.
	function automatic hbd_in_t load_item(input logic [IDX_W-1:0] idx, input logic leaf,
			input logic [SYM_W-1:0] sym, input logic [IDX_W-1:0] l, input logic [IDX_W-1:0] r);
		hbd_in_t it;
		it.operation   = OP_LOAD;
		it.node_index  = idx;
		it.node_leaf   = leaf;
		it.node_symbol = sym;
		it.left_child  = l;
		it.right_child = r;
		it.data_byte   = 8'($urandom_range(255));
		return it;
	endfunction

	// Likewise the node fields of a decode are ignored and carry random noise.
	function automatic hbd_in_t decode_item(input logic [7:0] bits);
		hbd_in_t it;
		it.operation   = OP_DECODE;
		it.node_index  = 9'($urandom_range(511));
		it.node_leaf   = 1'($urandom_range(1));
		it.node_symbol = 8'($urandom_range(255));
		it.left_child  = 9'($urandom_range(511));
		it.right_child = 9'($urandom_range(511));
		it.data_byte   = bits;
		return it;
	endfunction

	// Offer one transaction on the item channel, after a random idle gap. Valid is left high
	// after acceptance so that back-to-back transactions never lower and raise it in the same
	// time step; drain_results lowers it whenever the sender stops.
	task automatic send_item(input hbd_in_t it);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sent_items++;
		if (it.operation == OP_LOAD)
			store_node(it);
		else
			walk_byte(it.data_byte);
	endtask

	// Stop sending, wait for every owed symbol, then give a decode that yields nothing time to
	// finish its walk. The block is idle afterwards, so the root register may be written.
	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_syms.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A root write also moves the walk to the new root, dropping any partial code.
	task automatic write_root(input logic [IDX_W-1:0] root);
		cfg_data  <= root;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		tree_root = root;
		walk_pos  = root;
	endtask

	// A small fixed tree at root 0: code 0 is 0x00, code 10 is 0xFF, code 11 is 0xA5. Nodes are
	// written children first. Node 511 loops on a 1 bit and leaves on a 0 bit; node 510 loops
	// on both bits and never reaches a leaf. Decoding starts at the reset root without any
	// root write, and one code runs across a byte boundary.
	task automatic test_tree_walk();
		send_item(load_item(9'd1,   1'b1, 8'h00, 9'd1,   9'd1));
		send_item(load_item(9'd511, 1'b0, 8'h3C, 9'd1,   9'd511));
		send_item(load_item(9'd3,   1'b1, 8'hFF, 9'd3,   9'd3));
		send_item(load_item(9'd4,   1'b1, 8'hA5, 9'd4,   9'd511));
		send_item(load_item(9'd2,   1'b0, 8'h5A, 9'd3,   9'd4));
		send_item(load_item(9'd0,   1'b0, 8'hC3, 9'd1,   9'd2));
		send_item(load_item(9'd510, 1'b0, 8'h81, 9'd510, 9'd510));
		send_item(decode_item(8'h00));	// eight symbols, the most one byte can give
		send_item(decode_item(8'hFF));
		send_item(decode_item(8'h01));
		send_item(decode_item(8'h80));	// ends in the middle of a code
		send_item(decode_item(8'h01));	// which this byte completes
		send_item(decode_item(8'hC6));
	endtask

	// Root register cases: discarding a partial code, a leaf as root, the highest index as
	// root, and a root from which no leaf is ever reached.
	task automatic test_root_register();
		send_item(decode_item(8'h80));
		drain_results();
		write_root(9'd0);
		send_item(decode_item(8'h02));
		drain_results();
		write_root(9'd3);
		send_item(decode_item(8'h96));
		drain_results();
		write_root(9'd511);
		send_item(decode_item(8'h00));
		send_item(decode_item(8'hFF));
		send_item(decode_item(8'h7F));
		drain_results();
		write_root(9'd510);
		send_item(decode_item(8'h5A));
		drain_results();
		write_root(9'd0);
	endtask

	// The receiver holds off for a long stretch while decodes keep coming, so the block fills
	// and stalls its input. Then the sender pauses until every symbol is out, and resumes.
	task automatic test_backpressure();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_trigger++;
		repeat (30) send_item(decode_item(8'($urandom_range(255))));
		drain_results();
		repeat (8) send_item(decode_item(8'($urandom_range(255))));
	endtask

	// Random traffic under one idling setting. Each round builds a fresh random tree of a few
	// leaves, bottom up at distinct random indexes, points the root at it (now and then at any
	// written node instead), and decodes random bytes with a sprinkling of node rewrites.
	task automatic test_random_traffic(input int tx_pct, input int rx_pct);
		int               target;
		int               leaves;
		int               k;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] l;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] pool[$];
		bit               taken[NODES];
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		target = sent_items + 40;
		while (sent_items < target) begin
			taken  = '{default: 1'b0};
			leaves = $urandom_range(2, 12);
			for (k = 0; k < leaves; k++) begin
				do idx = 9'($urandom_range(511)); while (taken[idx]);
				taken[idx] = 1'b1;
				// A leaf's children only matter when it serves as root; point them at itself
				// or at any node that is already loaded.
				l = (written_list.size() == 0 || $urandom_range(1)) ? idx : any_written();
				r = (written_list.size() == 0 || $urandom_range(1)) ? idx : any_written();
				send_item(load_item(idx, 1'b1, 8'($urandom_range(255)), l, r));
				pool.insert(pool.size(), idx);
			end
			// Join two random subtrees under a new inner node until one root is left.
			while (pool.size() > 1) begin
				k = $urandom_range(pool.size() - 1);
				a = pool[k];
				pool.delete(k);
				k = $urandom_range(pool.size() - 1);
				b = pool[k];
				pool.delete(k);
				do idx = 9'($urandom_range(511)); while (taken[idx]);
				taken[idx] = 1'b1;
				send_item(load_item(idx, 1'b0, 8'($urandom_range(255)), a, b));
				pool.insert(pool.size(), idx);
			end
			drain_results();
			write_root(($urandom_range(3) == 0) ? any_written() : pool[0]);
			pool.delete();
			repeat (25) begin
				if ($urandom_range(99) < 12)
					send_item(load_item(9'($urandom_range(511)), 1'($urandom_range(1)),
						8'($urandom_range(255)), any_written(), any_written()));
				else
					send_item(decode_item(8'($urandom_range(255))));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_tree_walk();
		test_root_register();
		test_backpressure();
		test_random_traffic(0, 0);
		test_random_traffic(68, 0);
		test_random_traffic(0, 68);
		test_random_traffic(31, 31);
		drain_results();
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// Receiver: random stalls at the current rate, plus the one long hold-off, counted here.
	int hold_taken = 0;
	int hold_left  = 0;
	always @(posedge clk) begin
		if (hold_trigger != hold_taken) begin
			hold_taken = hold_trigger;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Each accepted result transaction is compared with the oldest owed symbol.
	always @(posedge clk) begin : check_results
		hbd_out_t want;
		if (result_valid && result_ready) begin
			if (pending_syms.size() == 0) begin
				$error("result with nothing expected: symbol %0h, last_of_byte %0b",
					result.symbol, result.last_of_byte);
				errors++;
			end else begin
				want = pending_syms.pop_front();
				if (result.symbol !== want.symbol) begin
					$error("symbol: expected %0h, got %0h", want.symbol, result.symbol);
					errors++;
				end
				if (result.last_of_byte !== want.last_of_byte) begin
					$error("last_of_byte: expected %0b, got %0b", want.last_of_byte,
						result.last_of_byte);
					errors++;
				end
			end
		end
	end

	// Watchdog: too many cycles in a row with no transaction on any channel ends the run.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

endmodule

### sim.f
rtl/core/hbd_pkg.sv
rtl/core/hbd_node_mem.sv
rtl/core/hbd_sym_buf.sv
rtl/core/hbd_walk.sv
rtl/core/huffman_tree_bit_decoder.sv
dv/testbench.sv
